// ----- sv/rle_pkg.sv -----
// Shared types and constants for the run-length byte stream decoder.
// No dependencies; used by every other file of the block.
package rle_pkg;

  // Shortest run a run header can describe, and the output beat width in bytes
  localparam int unsigned MIN_RUN    = 3;
  localparam int unsigned BEAT_BYTES = 4;
  localparam int unsigned BEAT_EFF   = (BEAT_BYTES < 1) ? 1 :
                                       ((BEAT_BYTES > 4) ? 4 : BEAT_BYTES);

  typedef enum logic [1:0] {
    OP_RUN,
    OP_LIT,
    OP_TRUNC
  } op_t;

  // One classified token step, passed from front end to expander
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [7:0] len;
    logic       last;
    logic       trunc_after;
  } cmd_t;

endpackage

// ----- sv/rle_front.sv -----
// Front end: parses headers, tracks the token phase and classifies each byte.
// Depends on rle_pkg for cmd_t and MIN_RUN.
module rle_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     comp_byte,
  input  logic           stream_end,
  output logic           push,
  output rle_pkg::cmd_t  cmd
);

  localparam logic [7:0] LEN_MASK = 8'h7F;
  localparam int unsigned RUN_BIT = 7;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RUNVAL,
    PH_LITERAL
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] pending, pending_next;
  logic       hit;
  logic [7:0] low;
  logic [8:0] run_sum;
  logic [7:0] run_len;
  logic [7:0] lit_left;

  always_comb begin
    low      = comp_byte & LEN_MASK;
    run_sum  = {1'b0, low} + 9'(rle_pkg::MIN_RUN);
    run_len  = run_sum[8] ? 8'hFF : run_sum[7:0];
    lit_left = (pending != 8'd0) ? pending - 8'd1 : 8'd0;

    phase_next       = phase;
    pending_next     = pending;
    hit              = 1'b0;
    cmd.op           = rle_pkg::OP_LIT;
    cmd.data         = comp_byte;
    cmd.len          = 8'd0;
    cmd.last         = 1'b0;
    cmd.trunc_after  = 1'b0;

    case (phase)
      PH_RUNVAL: begin
        cmd.op       = rle_pkg::OP_RUN;
        cmd.len      = pending;
        cmd.last     = 1'b1;
        hit          = (pending != 8'd0);
        phase_next   = PH_HEADER;
        pending_next = 8'd0;
      end
      PH_LITERAL: begin
        cmd.op          = rle_pkg::OP_LIT;
        cmd.last        = (lit_left == 8'd0);
        cmd.trunc_after = stream_end && (lit_left != 8'd0);
        hit             = 1'b1;
        pending_next    = lit_left;
        phase_next      = (lit_left == 8'd0) ? PH_HEADER : PH_LITERAL;
      end
      default: begin
        if (comp_byte[RUN_BIT]) begin
          pending_next = run_len;
          phase_next   = (run_len == 8'd0) ? PH_HEADER : PH_RUNVAL;
        end else begin
          pending_next = low;
          phase_next   = (low == 8'd0) ? PH_HEADER : PH_LITERAL;
        end
        // stream stopped right after a header: report the broken token
        if (stream_end && phase_next != PH_HEADER) begin
          cmd.op = rle_pkg::OP_TRUNC;
          hit    = 1'b1;
        end
      end
    endcase

    if (stream_end) begin
      phase_next   = PH_HEADER;
      pending_next = 8'd0;
    end
  end

  assign push = accept && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEADER;
      pending <= 8'd0;
    end else if (accept) begin
      phase   <= phase_next;
      pending <= pending_next;
    end
  end

endmodule

// ----- sv/rle_queue.sv -----
// Short command queue between front end and expander, show-ahead head.
// Depends on rle_pkg for cmd_t.
module rle_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rle_pkg::cmd_t  push_cmd,
  output logic           push_ready,
  output logic           head_valid,
  output rle_pkg::cmd_t  head_cmd,
  input  logic           pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rle_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("queue fill above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ----- sv/rle_back.sv -----
// Expander: turns queued commands into output beats held in an output register.
// Depends on rle_pkg for cmd_t and BEAT_EFF.
module rle_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  rle_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_bytes,
  output logic [2:0]     out_count,
  output logic           token_last,
  output logic           truncated
);

  localparam logic [2:0] BEAT_MAX = 3'(rle_pkg::BEAT_EFF);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_TRUNC
  } bk_state_t;

  bk_state_t  state;
  logic [7:0] left;
  logic [7:0] run_byte;
  logic       load;
  logic [7:0] src_len;
  logic [7:0] src_byte;
  logic [2:0] take;
  logic [7:0] rem;

  function automatic logic [31:0] beat_word(input logic [7:0] b, input logic [2:0] n);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < n) begin
        w[8*i +: 8] = b;
      end
    end
    return w;
  endfunction

  assign load    = !out_valid || out_ready;
  assign cmd_pop = load && (state == BK_IDLE) && cmd_valid;

  always_comb begin
    src_len  = (state == BK_RUN) ? left : cmd.len;
    src_byte = (state == BK_RUN) ? run_byte : cmd.data;
    take     = (src_len > 8'(BEAT_MAX)) ? BEAT_MAX : src_len[2:0];
    rem      = src_len - 8'(take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      left      <= 8'd0;
    end else begin
      if (load) begin
        // a free output register fills whenever there is a beat to make
        out_valid <= (state == BK_RUN) || (state == BK_TRUNC) ||
                     ((state == BK_IDLE) && cmd_valid);
        case (state)
          BK_IDLE: begin
            if (cmd_valid) begin
              case (cmd.op)
                rle_pkg::OP_RUN: begin
                  out_bytes  <= beat_word(src_byte, take);
                  out_count  <= take;
                  token_last <= (rem == 8'd0);
                  truncated  <= 1'b0;
                  left       <= rem;
                  run_byte   <= cmd.data;
                  if (rem != 8'd0) begin
                    state <= BK_RUN;
                  end
                end
                rle_pkg::OP_LIT: begin
                  out_bytes  <= {24'd0, cmd.data};
                  out_count  <= 3'd1;
                  token_last <= cmd.last;
                  truncated  <= 1'b0;
                  if (cmd.trunc_after) begin
                    state <= BK_TRUNC;
                  end
                end
                default: begin
                  out_bytes  <= '0;
                  out_count  <= 3'd0;
                  token_last <= 1'b0;
                  truncated  <= 1'b1;
                end
              endcase
            end
          end
          BK_RUN: begin
            out_bytes  <= beat_word(src_byte, take);
            out_count  <= take;
            token_last <= (rem == 8'd0);
            truncated  <= 1'b0;
            left       <= rem;
            if (rem == 8'd0) begin
              state <= BK_IDLE;
            end
          end
          BK_TRUNC: begin
            out_bytes  <= '0;
            out_count  <= 3'd0;
            token_last <= 1'b0;
            truncated  <= 1'b1;
            state      <= BK_IDLE;
          end
          default: begin
            state <= BK_IDLE;
          end
        endcase
      end
    end
  end

  a_trunc_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated) |-> (out_count == 3'd0 && out_bytes == 32'd0 && !token_last))
    else $error("truncation beat carries data");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !truncated) |-> (out_count != 3'd0 && out_count <= BEAT_MAX))
    else $error("data beat count out of range");

  a_run_left: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) |-> (left != 8'd0))
    else $error("run expansion with nothing left");

endmodule

// ----- sv/rle_byte_stream_decoder.sv -----
// Top level of the run-length byte stream decoder: front end, queue, expander.
// Depends on rle_pkg, rle_front, rle_queue and rle_back.
//
//   channel | signals                                        | role
//   --------+------------------------------------------------+-------------------
//   in      | in_valid, in_ready, comp_byte, stream_end      | compressed bytes
//   out     | out_valid, out_ready, out_bytes, out_count,    | decoded beats,
//           | token_last, truncated                          | up to 4 bytes each
//
// A literal byte makes one beat; a literal byte that ends the stream inside
// its group adds a truncation beat. A run value byte makes ceil(len / 4)
// beats in the expander, one beat per cycle while out_ready is not held low,
// where len is (header & 0x7F) + 3. The command queue (QUEUE_DEPTH entries)
// lets the front end keep taking bytes while a run expands, until the queue
// fills.
// Reset (rst, synchronous) returns both parts to idle and empties the queue.
// A stall on out_ready holds the output register and backs up into the queue.
module rle_byte_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  comp_byte,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_bytes,
  output logic [2:0]  out_count,
  output logic        token_last,
  output logic        truncated
);

  logic          accept;
  logic          push;
  rle_pkg::cmd_t push_cmd;
  logic          head_valid;
  rle_pkg::cmd_t head_cmd;
  logic          pop;

  assign accept = in_valid && in_ready;

  rle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .comp_byte  (comp_byte),
    .stream_end (stream_end),
    .push       (push),
    .cmd        (push_cmd)
  );

  rle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (in_ready),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  rle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (head_valid),
    .cmd        (head_cmd),
    .cmd_pop    (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_bytes  (out_bytes),
    .out_count  (out_count),
    .token_last (token_last),
    .truncated  (truncated)
  );

endmodule

// ----- test/rle_byte_stream_decoder_tb.sv -----
// Self-checking bench for rle_byte_stream_decoder: drives compressed bytes,
// predicts every decoded beat and truncation flag, and checks them in order.
// Depends on rle_pkg and the decoder RTL.
`timescale 1ns / 100ps

module rle_byte_stream_decoder_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 20;

  typedef enum logic [1:0] {
    EXP_HEADER,
    EXP_RUN_VALUE,
    IN_LITERAL
  } dec_phase_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  count;
    logic        last;
    logic        trunc;
  } beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  comp_byte;
  logic        stream_end;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_bytes;
  logic [2:0]  out_count;
  logic        token_last;
  logic        truncated;

  beat_t       expected_beats[$];
  dec_phase_t  dec_phase;
  logic [7:0]  bytes_left;
  bit          quiet;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned beats_checked;
  int unsigned trunc_seen;
  int unsigned error_count;

  rle_byte_stream_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .comp_byte  (comp_byte),
    .stream_end (stream_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_bytes  (out_bytes),
    .out_count  (out_count),
    .token_last (token_last),
    .truncated  (truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the beats that one compressed byte produces
  function automatic void predict_decode(input logic [7:0] b, input logic fin);
    int unsigned left;
    int unsigned take;
    int unsigned run_len;
    int unsigned i;
    beat_t       bt;
    case (dec_phase)
      EXP_RUN_VALUE: begin
        left = bytes_left;
        while (left > 0) begin
          take = (left > rle_pkg::BEAT_EFF) ? rle_pkg::BEAT_EFF : left;
          bt = '0;
          for (i = 0; i < take; i++) bt.bytes[8*i +: 8] = b;
          left -= take;
          bt.count = 3'(take);
          bt.last  = (left == 0);
          expected_beats.push_back(bt);
        end
        dec_phase  = EXP_HEADER;
        bytes_left = '0;
      end
      IN_LITERAL: begin
        left = (bytes_left > 0) ? bytes_left - 1 : 0;
        bt = '0;
        bt.bytes[7:0] = b;
        bt.count      = 3'd1;
        bt.last       = (left == 0);
        expected_beats.push_back(bt);
        bytes_left = 8'(left);
        dec_phase  = (left == 0) ? EXP_HEADER : IN_LITERAL;
      end
      default: begin
        if (b[7]) begin
          run_len = b[6:0] + rle_pkg::MIN_RUN;
          if (run_len > 255) run_len = 255;
          bytes_left = 8'(run_len);
          dec_phase  = (run_len == 0) ? EXP_HEADER : EXP_RUN_VALUE;
        end else begin
          bytes_left = {1'b0, b[6:0]};
          dec_phase  = (b[6:0] == 0) ? EXP_HEADER : IN_LITERAL;
        end
      end
    endcase
    if (fin) begin
      // Stream stopped inside a token: flag it and fall back to a header
      if (dec_phase != EXP_HEADER) begin
        bt = '0;
        bt.trunc = 1'b1;
        expected_beats.push_back(bt);
      end
      dec_phase  = EXP_HEADER;
      bytes_left = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Present one request and hold it until the decoder takes it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    comp_byte  <= b;
    stream_end <= fin;
    predict_decode(b, fin);
    bytes_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // One well-formed token with random content; sometimes cut short by the end flag
  task automatic send_token();
    logic [7:0]  tok[$];
    int unsigned kind;
    int unsigned n;
    int unsigned cut;
    int unsigned r;
    int unsigned i;
    kind = $urandom_range(99);
    if (kind < 50) begin
      n = ($urandom_range(99) < 15) ? $urandom_range(127) : $urandom_range(12);
      tok.push_back({1'b1, 7'(n)});
      tok.push_back(8'($urandom_range(255)));
    end else if (kind < 95) begin
      n = ($urandom_range(99) < 5) ? $urandom_range(127) : $urandom_range(1, 8);
      tok.push_back({1'b0, 7'(n)});
      for (i = 0; i < n; i++) tok.push_back(8'($urandom_range(255)));
    end else begin
      tok.push_back(8'h00);
    end
    r   = $urandom_range(99);
    cut = tok.size() - 1;
    if (r < 6 && tok.size() > 1) cut = $urandom_range(tok.size() - 2);
    for (i = 0; i <= cut; i++)
      send_byte(tok[i], (i == cut) && (r < 14));
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b0);                          // empty literal group
    send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);  // shortest run
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);  // longest run
    send_byte(8'h81, 1'b0); send_byte(8'hA5, 1'b0);  // run filling one beat exactly
    send_byte(8'h84, 1'b0); send_byte(8'h5A, 1'b0);  // run with a partial last beat
    send_byte(8'h02, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    // literal group cut short after two of its bytes
    send_byte(8'h7F, 1'b0); send_byte(8'h11, 1'b0); send_byte(8'h22, 1'b1);
    send_byte(8'h85, 1'b1);                          // end straight after a run header
    send_byte(8'h80, 1'b0); send_byte(8'h33, 1'b1);  // clean end on a run value
    send_byte(8'h00, 1'b1);                          // clean end on an empty group
    send_byte(8'h01, 1'b1);                          // end straight after a literal header
  endtask

  task automatic test_random_streams(input int unsigned budget);
    int unsigned stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) send_token();
  endtask

  // Full rate on both sides to keep the queue and the expander busy
  task automatic test_back_to_back(input int unsigned budget);
    quiet = 1'b1;
    test_random_streams(budget);
    quiet = 1'b0;
  endtask

  // Unstructured bytes, end flags anywhere
  task automatic test_noise(input int unsigned budget);
    int unsigned i;
    for (i = 0; i < budget; i++)
      send_byte(8'($urandom_range(255)), $urandom_range(99) < 15);
  endtask

  always @(posedge clk) begin
    if (quiet) out_ready <= 1'b1;
    else       out_ready <= ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_count, expected_beats.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_bytes, 32'h0);
      end else begin
        want = expected_beats.pop_front();
        if (out_bytes !== want.bytes)  report_mismatch("out_bytes", out_bytes, want.bytes);
        if (out_count !== want.count)
          report_mismatch("out_count", 32'(out_count), 32'(want.count));
        if (token_last !== want.last)
          report_mismatch("token_last", 32'(token_last), 32'(want.last));
        if (truncated !== want.trunc)
          report_mismatch("truncated", 32'(truncated), 32'(want.trunc));
        beats_checked++;
        if (want.trunc) trunc_seen++;
      end
    end
  end

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    comp_byte   = '0;
    stream_end  = 1'b0;
    out_ready   = 1'b0;
    quiet       = 1'b0;
    dec_phase   = EXP_HEADER;
    bytes_left  = '0;
    cycle_count = 0;
    bytes_sent  = 0;
    beats_checked = 0;
    trunc_seen  = 0;
    error_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_streams(180);
    test_back_to_back(60);
    test_noise(40);
    test_random_streams(60);
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Drove %0d compressed bytes; checked %0d decoded beats, %0d of them truncations.",
             bytes_sent, beats_checked, trunc_seen);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- rle_byte_stream_decoder.f -----
sv/rle_pkg.sv
sv/rle_front.sv
sv/rle_queue.sv
sv/rle_back.sv
sv/rle_byte_stream_decoder.sv
test/rle_byte_stream_decoder_tb.sv
